@@ sv/bnv_pkg.sv @@
package bnv_pkg;

  localparam int unsigned KindW  = 3;
  localparam int unsigned CharW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned LimitW = 8;
  localparam int unsigned ElemW  = 2;

  localparam logic [KindW-1:0] KIND_BUS    = 3'd0;
  localparam logic [KindW-1:0] KIND_UNIQUE = 3'd1;
  localparam logic [KindW-1:0] KIND_IFACE  = 3'd2;
  localparam logic [KindW-1:0] KIND_MEMBER = 3'd3;
  localparam logic [KindW-1:0] KIND_PATH   = 3'd4;

  localparam logic [CharW-1:0] CH_NUL        = 8'h00;
  localparam logic [CharW-1:0] CH_COLON      = 8'h3A;
  localparam logic [CharW-1:0] CH_SLASH      = 8'h2F;
  localparam logic [CharW-1:0] CH_DOT        = 8'h2E;
  localparam logic [CharW-1:0] CH_DASH       = 8'h2D;
  localparam logic [CharW-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CharW-1:0] CH_0          = 8'h30;
  localparam logic [CharW-1:0] CH_9          = 8'h39;
  localparam logic [CharW-1:0] CH_LA         = 8'h61;
  localparam logic [CharW-1:0] CH_LZ         = 8'h7A;
  localparam logic [CharW-1:0] CH_UA         = 8'h41;
  localparam logic [CharW-1:0] CH_UZ         = 8'h5A;

  localparam logic [LimitW-1:0] LIMIT_RESET = 8'd255;
  localparam logic [ElemW-1:0]  ELEM_MAX    = 2'd3;
  localparam logic [LenW-1:0]   LEN_MAX     = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_CHAR    = 3'd1,
    ST_DIGIT_START = 3'd2,
    ST_EMPTY_ELEM  = 3'd3,
    ST_TOO_FEW     = 3'd4,
    ST_TOO_LONG    = 3'd5,
    ST_NO_LEAD     = 3'd6
  } status_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CharW-1:0] ch;
  } item_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             at_start;
    status_e          status;
    logic             has_chars;
    logic [ElemW-1:0] elem_cnt;
    logic [LenW-1:0]  char_cnt;
  } scan_t;

  typedef struct packed {
    status_e         status;
    logic [LenW-1:0] len;
  } result_t;

  function automatic logic is_digit(logic [CharW-1:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_word(logic [CharW-1:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
           is_digit(c) || (c == CH_UNDERSCORE);
  endfunction

endpackage

@@ sv/bnv_in_stage.sv @@
module bnv_in_stage import bnv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  take_i,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = valid_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ sv/bnv_step.sv @@
module bnv_step import bnv_pkg::*; (
  input  scan_t             scan_i,
  input  item_t             item_i,
  input  logic [LimitW-1:0] limit_i,
  output scan_t             scan_o,
  output logic              done_o,
  output result_t           result_o
);

  scan_t            w;
  logic             first;
  logic [CharW-1:0] c;
  logic             dash_ok;
  logic             digit_lead_ok;
  logic [CharW-1:0] sep;
  status_e          fin;

  always_comb begin
    first = scan_i.at_start;
    c     = item_i.ch;
    w     = scan_i;
    if (first) begin
      w.kind      = item_i.kind;
      w.status    = (item_i.kind > KIND_PATH) ? ST_BAD_CHAR : ST_OK;
      w.has_chars = 1'b0;
      w.elem_cnt  = '0;
      w.char_cnt  = '0;
      w.at_start  = 1'b0;
    end

    dash_ok       = (w.kind == KIND_BUS) || (w.kind == KIND_UNIQUE);
    digit_lead_ok = (w.kind == KIND_UNIQUE) || (w.kind == KIND_PATH);
    sep           = (w.kind == KIND_PATH) ? CH_SLASH : CH_DOT;

    // status at the terminator
    if (w.status != ST_OK) begin
      fin = w.status;
    end else if (first && ((w.kind == KIND_UNIQUE) || (w.kind == KIND_PATH))) begin
      fin = ST_NO_LEAD;
    end else if (w.kind == KIND_PATH) begin
      fin = (!w.has_chars && (w.elem_cnt != '0)) ? ST_EMPTY_ELEM : ST_OK;
    end else if (!w.has_chars) begin
      fin = ST_EMPTY_ELEM;
    end else if ((w.kind != KIND_MEMBER) && (w.elem_cnt == '0)) begin
      fin = ST_TOO_FEW;
    end else if (w.char_cnt > {{(LenW-LimitW){1'b0}}, limit_i}) begin
      fin = ST_TOO_LONG;
    end else begin
      fin = ST_OK;
    end

    result_o.status = fin;
    result_o.len    = w.char_cnt;
    done_o          = (c == CH_NUL);
    scan_o          = w;

    if (c == CH_NUL) begin
      scan_o.at_start  = 1'b1;
      scan_o.status    = ST_OK;
      scan_o.has_chars = 1'b0;
      scan_o.elem_cnt  = '0;
      scan_o.char_cnt  = '0;
    end else begin
      if (w.char_cnt != LEN_MAX) begin
        scan_o.char_cnt = w.char_cnt + 1'b1;
      end
      if (w.status == ST_OK) begin
        if (first && (w.kind == KIND_UNIQUE)) begin
          if (c != CH_COLON) begin
            scan_o.status = ST_NO_LEAD;
          end
        end else if (first && (w.kind == KIND_PATH)) begin
          if (c != CH_SLASH) begin
            scan_o.status = ST_NO_LEAD;
          end
        end else if ((c == sep) && (w.kind != KIND_MEMBER)) begin
          if (!w.has_chars) begin
            scan_o.status = ST_EMPTY_ELEM;
          end else begin
            scan_o.has_chars = 1'b0;
            if (w.elem_cnt != ELEM_MAX) begin
              scan_o.elem_cnt = w.elem_cnt + 1'b1;
            end
          end
        end else if (!(is_word(c) || (dash_ok && (c == CH_DASH)))) begin
          scan_o.status = ST_BAD_CHAR;
        end else if (is_digit(c) && !w.has_chars && !digit_lead_ok) begin
          scan_o.status = ST_DIGIT_START;
        end else begin
          scan_o.has_chars = 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/bus_name_validator.sv @@
// a terminator is held in the input register, then its result is registered in the output register
// throughput: one character per cycle unless stalled, results taken through an output register
// a character waits in the input register only while a terminator meets a full output
// reset: length limit returns to 255, string state clears, no result pending
module bus_name_validator import bnv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [CharW-1:0]  s_axis_tdata,   // char_code
  input  logic [KindW-1:0]  s_axis_tuser,   // name_kind
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [LenW-1:0]   m_axis_tdata,   // length
  output logic [2:0]        m_axis_tuser    // status
);

  item_t             in_item;
  item_t             cur_item;
  logic              cur_valid;
  logic              take;
  logic              out_free;
  logic              done;
  scan_t             scan_q, scan_d;
  result_t           res_d, res_q;
  logic              out_valid_q, out_valid_d;
  logic [LimitW-1:0] limit_q;

  assign in_item.kind = s_axis_tuser;
  assign in_item.ch   = s_axis_tdata;

  bnv_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (cur_valid),
    .take_i  (take),
    .item_o  (cur_item)
  );

  bnv_step u_step (
    .scan_i   (scan_q),
    .item_i   (cur_item),
    .limit_i  (limit_q),
    .scan_o   (scan_d),
    .done_o   (done),
    .result_o (res_d)
  );

  assign out_free    = !out_valid_q || m_axis_tready;
  assign take        = cur_valid && (!done || out_free);
  assign out_valid_d = (take && done) || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q            <= LIMIT_RESET;
      out_valid_q        <= 1'b0;
      scan_q.kind        <= KIND_BUS;
      scan_q.at_start    <= 1'b1;
      scan_q.status      <= ST_OK;
      scan_q.has_chars   <= 1'b0;
      scan_q.elem_cnt    <= '0;
      scan_q.char_cnt    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (take) begin
        scan_q <= scan_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && done) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q.len;
  assign m_axis_tuser  = res_q.status;

endmodule
